/* sv/sha_pkg.sv */
package sha_pkg;

    typedef logic [31:0] t_word;

    localparam logic [3:0] WORDS_PER_BLOCK_M1 = 4'd15;
    localparam logic [3:0] LEN_HI_SLOT = 4'd14;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_item;

    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_LAST = 2'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] word;
        logic [2:0]  count;
    } t_cmd;

    localparam t_word INITIAL_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word ror(input t_word v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

/* sv/sha_if.sv */
interface sha_in_if;
    import sha_pkg::*;
    logic  valid;
    logic  ready;
    t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest_word;
    modport source (output valid, output digest_word, output word_index,
                    output last_digest_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_digest_word, output ready);
endinterface

/* sv/sha_front.sv */
module sha_front import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha_in_if.sink      in_ch,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_ready
);

    logic [1:0] r_wp, r_rp, n_wp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    t_cmd       r_q [4];
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    assign in_ch.ready = (r_cnt != 3'd4);
    assign w_push = in_ch.valid && in_ch.ready;
    assign w_pop = o_cmd_valid && i_cmd_ready;
    assign o_cmd_valid = (r_cnt != 3'd0);
    assign o_cmd = r_q[r_rp];

    always_comb begin
        w_cmd.word = in_ch.payload.data_word;
        if (in_ch.payload.last_word) begin
            w_cmd.op = OP_LAST;
            w_cmd.count = (in_ch.payload.byte_count > 3'd4) ? 3'd4
                                                            : in_ch.payload.byte_count;
        end else begin
            w_cmd.op = OP_DATA;
            w_cmd.count = 3'd4;
        end
        n_wp = r_wp + {1'b0, w_push};
        n_rp = r_rp + {1'b0, w_pop};
        n_cnt = r_cnt + {2'b0, w_push} - {2'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* sv/sha_core.sv */
module sha_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_ready,
    sha_out_if.source   out_ch
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_LEN  = 3'd5;

    logic [2:0]  r_st, n_st;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [3:0]  r_fill;
    logic [63:0] r_bytes;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oi;
    logic        r_tail;
    logic        r_lenhi;
    logic        r_pad4;
    logic        r_marked;

    t_word w_push;
    logic  w_do_push;
    t_word w_wi, w_s0, w_s1, w_t1, w_t2, w_x15, w_x2;
    logic [63:0] w_bits;

    assign o_cmd_ready = (r_st == ST_IDLE);
    assign out_ch.valid = (r_st == ST_OUT);
    assign out_ch.digest_word = r_h[r_oi];
    assign out_ch.word_index = r_oi;
    assign out_ch.last_digest_word = (r_oi == 3'd7);
    assign w_bits = r_bytes << 3;

    always_comb begin
        w_x15 = r_w[1];
        w_x2 = r_w[14];
        w_s0 = ror(w_x15, 7) ^ ror(w_x15, 18) ^ (w_x15 >> 3);
        w_s1 = ror(w_x2, 17) ^ ror(w_x2, 19) ^ (w_x2 >> 10);
        w_wi = (r_rnd < 6'd16) ? r_w[0] : (r_w[0] + w_s0 + r_w[9] + w_s1);
        w_t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_rnd] + w_wi;
        w_t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_do_push = 1'b0;
        w_push = '0;
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    w_do_push = (i_cmd.op == OP_DATA) || (i_cmd.count == 3'd4);
                    w_push = i_cmd.word;
                    if (i_cmd.op == OP_LAST) begin
                        if (w_do_push && r_fill == WORDS_PER_BLOCK_M1) begin
                            n_st = ST_COMP;
                        end else begin
                            n_st = ST_PAD;
                        end
                    end else if (r_fill == WORDS_PER_BLOCK_M1) begin
                        n_st = ST_COMP;
                    end
                end
            end
            ST_PAD: begin
                w_do_push = 1'b1;
                if (!r_marked) begin
                    if (r_pad4) begin
                        w_push = 32'h80000000;
                    end else begin
                        case (r_bytes[1:0])
                            2'd1: w_push = {r_w[15][31:24], 24'h800000};
                            2'd2: w_push = {r_w[15][31:16], 16'h8000};
                            2'd3: w_push = {r_w[15][31:8], 8'h80};
                            default: w_push = 32'h80000000;
                        endcase
                    end
                end else if (r_fill == LEN_HI_SLOT) begin
                    w_push = w_bits[63:32];
                end
                if (r_fill == WORDS_PER_BLOCK_M1) begin
                    n_st = ST_COMP;
                end else if (r_fill == LEN_HI_SLOT && r_marked) begin
                    n_st = ST_LEN;
                end
            end
            ST_LEN: begin
                w_do_push = 1'b1;
                w_push = w_bits[31:0];
                n_st = ST_COMP;
            end
            ST_COMP: begin
                if (r_rnd == 6'd63) begin
                    n_st = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_tail && r_fill == 4'd0 && r_lenhi) begin
                    n_st = ST_OUT;
                end else if (r_tail) begin
                    n_st = ST_PAD;
                end else begin
                    n_st = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_ch.ready && r_oi == 3'd7) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_w[r_fill] <= w_push;
        end
        if (r_st == ST_IDLE && i_cmd_valid && i_cmd.op == OP_LAST && i_cmd.count != 3'd4) begin
            r_w[15] <= i_cmd.word;
        end
        if (r_st == ST_COMP) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_wi;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end else begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_fill <= '0;
            r_bytes <= '0;
            r_rnd <= '0;
            r_oi <= '0;
            r_tail <= 1'b0;
            r_lenhi <= 1'b0;
            r_pad4 <= 1'b0;
            r_marked <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INITIAL_HASH[i];
            end
        end else begin
            r_st <= n_st;
            if (w_do_push) begin
                r_fill <= r_fill + 4'd1;
            end
            if (r_st == ST_IDLE && i_cmd_valid) begin
                r_bytes <= r_bytes + {61'b0, i_cmd.count};
                if (i_cmd.op == OP_LAST) begin
                    r_tail <= 1'b1;
                    r_pad4 <= (i_cmd.count == 3'd4);
                end
            end
            if (r_st == ST_PAD) begin
                r_marked <= 1'b1;
                if (r_marked && r_fill == LEN_HI_SLOT) begin
                    r_lenhi <= 1'b1;
                end
            end
            if (r_st == ST_COMP) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (r_st == ST_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (r_st == ST_OUT && out_ch.ready) begin
                r_oi <= r_oi + 3'd1;
                if (r_oi == 3'd7) begin
                    r_bytes <= '0;
                    r_tail <= 1'b0;
                    r_lenhi <= 1'b0;
                    r_pad4 <= 1'b0;
                    r_marked <= 1'b0;
                    r_fill <= '0;
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= INITIAL_HASH[i];
                    end
                end
            end
        end
    end

endmodule

/* sv/sha256_message_hasher.sv */
// A data word enters the block buffer; each full block of sixteen words is then compressed
// round by round and added into the hash. A message's last word adds padding, one or two
// compressions, and eight digest words, each handed over when accepted downstream.
// A four-entry queue decouples input acceptance from the compression engine.
// Synchronous active-low reset restores the initial hash value and clears all counters.
module sha256_message_hasher import sha_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    logic w_cmd_valid, w_cmd_ready;
    t_cmd w_cmd;

    sha_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    sha_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .out_ch      (out_ch)
    );

endmodule
